>>> rtl/core/laplacian_sharpen_stream_core_assert.svh
// Assertion macros used by the checker file of the sharpening core.
`ifndef LAPLACIAN_SHARPEN_STREAM_CORE_ASSERT_SVH
`define LAPLACIAN_SHARPEN_STREAM_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define LSS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lss: property violated");

// Clocked assertion that is also checked during and just after reset.
`define LSS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lss: reset property violated");

`endif

>>> rtl/core/lss_pkg.sv
// Shared types and constants of the Laplacian sharpening stream core.
package lss_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int COLS_W     = 11;
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [PIX_W-1:0]  PIX_MAX   = 8'd255;
    localparam logic [COLS_W-1:0] COLS_RST  = 11'd1024;
    localparam logic [ROW_W-1:0]  ROWS_RST  = 12'd1024;
    localparam logic [COLS_W-1:0] COLS_LIM  = COLS_W'(MAX_COLS);

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_t;

    typedef enum logic {
        REG_IMAGE_COLS = 1'b0,
        REG_IMAGE_ROWS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic             frame_end;
        logic             row_end;
        logic [PIX_W-1:0] pixel;
    } res_t;

endpackage

>>> rtl/core/laplacian_sharpen_stream_core.sv
// Streaming 3x3 cross Laplacian sharpening core, the top level.
//
// Input items arrive on the s_ channel: s_tuser selects a pixel (0) or a drain tick (1),
// s_tdata carries the grey level. Pixels come in raster order; the result for row r is
// returned while row r+1 comes in, so the stream trails the input by one line. Once the
// last pixel of the frame is in, each drain tick returns one pixel of the final row.
// Results leave on the m_ channel with m_tuser marking the end of a row and m_tlast the
// end of the frame. A result passes the second stage and then the output queue.
// One item is taken every cycle while s_tready is high; both line memories are read at
// accept time and written back in the cycle after, with data forwarded when the next
// item reads the entry just written (single-column frames and the wrap to a new row).
// Results pass through a four-entry output queue; s_tready only drops when that queue
// and the item in flight would fill it, so a stalled receiver holds up the input
// only after a few items. Configuration is written through cfg_we, cfg_addr and
// cfg_wdata; the user must do so only while the core is idle, and the core does not
// enforce it. Reset restores a 1024 x 1024 frame, clears the position counters and
// empties the queue; the line memories are not cleared and need no clearing pass.
module laplacian_sharpen_stream_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] pixel_in
    input  logic                    s_tuser,   // [0] req_type
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // [7:0] pixel_out
    output logic                    m_tuser,   // [0] row_end
    output logic                    m_tlast,
    input  logic                    cfg_we,
    input  lss_pkg::cfg_reg_t       cfg_addr,
    input  logic [lss_pkg::CFG_W-1:0] cfg_wdata
);
    import lss_pkg::*;

    // Configuration and position state
    logic [COLS_W-1:0] image_cols_reg;
    logic [ROW_W-1:0]  image_rows_reg;
    logic [COL_W-1:0]  col_count_reg,   col_count_next;
    logic [ROW_W-1:0]  row_count_reg,   row_count_next;
    logic [COL_W-1:0]  drain_count_reg, drain_count_next;
    logic [PIX_W-1:0]  left_reg;

    // Line memories and their read data
    logic [PIX_W-1:0] upper_mem  [MAX_COLS];
    logic [PIX_W-1:0] middle_mem [MAX_COLS];
    logic [PIX_W-1:0] mid_a_reg, mid_b_reg, up_reg;

    // Forwarding of the entry written in the same cycle as it is read
    logic             fwd_a_reg, fwd_b_reg, fwd_u_reg;
    logic [PIX_W-1:0] fwd_mid_reg, fwd_up_reg;

    // Second stage
    logic             s1_wr_reg, s1_push_reg, s1_drain_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_border_reg, s1_row_end_reg, s1_frame_end_reg;

    // Output queue
    res_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg, fifo_cnt_next;

    logic [COLS_W-1:0] cols_eff;
    logic [COL_W-1:0]  cols_m1;
    logic [ROW_W-1:0]  rows_eff;
    logic              acc, is_drain, frame_done;
    logic              pix_ok, drain_ok, produce;
    logic [COL_W-1:0]  c_sel, d_sel, rd_a, rd_b;
    logic              last_c, last_d, border;
    logic [PIX_W-1:0]  centre, up_pix, right_pix, result_pix;
    logic signed [11:0] sharp;
    logic [FIFO_AW+1:0] occupancy;
    logic              pop;
    res_t              push_item;

    always_comb begin
        if (image_cols_reg == '0) begin
            cols_eff = COLS_W'(1);
        end else if (image_cols_reg > COLS_LIM) begin
            cols_eff = COLS_LIM;
        end else begin
            cols_eff = image_cols_reg;
        end
        cols_m1  = COL_W'(cols_eff - COLS_W'(1));
        rows_eff = (image_rows_reg == '0) ? ROW_W'(1) : image_rows_reg;
    end

    assign occupancy = (FIFO_AW+2)'(fifo_cnt_reg) + (FIFO_AW+2)'(s1_push_reg);
    assign s_tready  = occupancy < (FIFO_AW+2)'(FIFO_DEPTH);
    assign acc       = s_tvalid && s_tready;
    assign is_drain  = (req_t'(s_tuser) == REQ_DRAIN);
    assign frame_done = row_count_reg >= rows_eff;
    assign pix_ok    = acc && !is_drain && !frame_done;
    assign drain_ok  = acc && is_drain && frame_done;
    assign produce   = pix_ok && (row_count_reg != '0);

    // A position left beyond the width by a register change counts as the row's end.
    assign c_sel  = (col_count_reg > cols_m1) ? cols_m1 : col_count_reg;
    assign d_sel  = (drain_count_reg > cols_m1) ? cols_m1 : drain_count_reg;
    assign last_c = (c_sel == cols_m1);
    assign last_d = (d_sel == cols_m1);
    assign border = (c_sel == '0) || last_c || (row_count_reg == ROW_W'(1))
                    || (row_count_reg == rows_eff);
    assign rd_a   = is_drain ? d_sel : c_sel;
    assign rd_b   = c_sel + COL_W'(1);

    always_comb begin
        col_count_next   = col_count_reg;
        row_count_next   = row_count_reg;
        drain_count_next = drain_count_reg;
        if (pix_ok) begin
            if (last_c) begin
                col_count_next = '0;
                row_count_next = row_count_reg + ROW_W'(1);
            end else begin
                col_count_next = c_sel + COL_W'(1);
            end
        end else if (drain_ok) begin
            if (last_d) begin
                drain_count_next = '0;
                col_count_next   = '0;
                row_count_next   = '0;
            end else begin
                drain_count_next = d_sel + COL_W'(1);
            end
        end
    end

    // Second stage: neighbourhood with forwarded data, sharpening and clamping.
    always_comb begin
        centre    = fwd_a_reg ? fwd_mid_reg : mid_a_reg;
        right_pix = fwd_b_reg ? fwd_mid_reg : mid_b_reg;
        up_pix    = fwd_u_reg ? fwd_up_reg  : up_reg;
        sharp = $signed({2'b00, centre, 2'b00}) + $signed({4'b0000, centre})
                - $signed({4'b0000, up_pix}) - $signed({4'b0000, left_reg})
                - $signed({4'b0000, right_pix}) - $signed({4'b0000, s1_pix_reg});
        if (s1_drain_reg || s1_border_reg) begin
            result_pix = centre;
        end else if (sharp[11]) begin
            result_pix = '0;
        end else if (|sharp[10:8]) begin
            result_pix = PIX_MAX;
        end else begin
            result_pix = sharp[7:0];
        end
        push_item.pixel     = result_pix;
        push_item.row_end   = s1_row_end_reg;
        push_item.frame_end = s1_frame_end_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_wr_reg) begin
            middle_mem[s1_addr_reg] <= s1_pix_reg;
            upper_mem[s1_addr_reg]  <= centre;
        end
        mid_a_reg <= middle_mem[rd_a];
        mid_b_reg <= middle_mem[rd_b];
        up_reg    <= upper_mem[c_sel];
    end

    assign pop = m_tvalid && m_tready;

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (s1_push_reg && !pop) begin
            fifo_cnt_next = fifo_cnt_reg + (FIFO_AW+1)'(1);
        end else if (!s1_push_reg && pop) begin
            fifo_cnt_next = fifo_cnt_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_cols_reg   <= COLS_RST;
            image_rows_reg   <= ROWS_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            drain_count_reg  <= '0;
            left_reg         <= '0;
            fwd_a_reg        <= 1'b0;
            fwd_b_reg        <= 1'b0;
            fwd_u_reg        <= 1'b0;
            s1_wr_reg        <= 1'b0;
            s1_push_reg      <= 1'b0;
            s1_drain_reg     <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fifo_cnt_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_IMAGE_COLS: image_cols_reg <= cfg_wdata[COLS_W-1:0];
                    REG_IMAGE_ROWS: image_rows_reg <= cfg_wdata[ROW_W-1:0];
                    default: ;
                endcase
            end
            col_count_reg   <= col_count_next;
            row_count_reg   <= row_count_next;
            drain_count_reg <= drain_count_next;
            if (s1_wr_reg) begin
                left_reg <= centre;
            end
            fwd_a_reg    <= s1_wr_reg && (s1_addr_reg == rd_a);
            fwd_b_reg    <= s1_wr_reg && (s1_addr_reg == rd_b);
            fwd_u_reg    <= s1_wr_reg && (s1_addr_reg == c_sel);
            s1_wr_reg    <= pix_ok;
            s1_push_reg  <= produce || drain_ok;
            s1_drain_reg <= drain_ok;
            if (s1_push_reg) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_mid_reg      <= s1_pix_reg;
        fwd_up_reg       <= centre;
        s1_addr_reg      <= rd_a;
        s1_pix_reg       <= s_tdata;
        s1_border_reg    <= border;
        s1_row_end_reg   <= is_drain ? last_d : last_c;
        s1_frame_end_reg <= is_drain && last_d;
        if (s1_push_reg) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg].pixel;
    assign m_tuser  = fifo_mem[rd_ptr_reg].row_end;
    assign m_tlast  = fifo_mem[rd_ptr_reg].frame_end;

endmodule

>>> rtl/core/lss_checker.sv
// Port-level checker of the sharpening core and its bind to the top level.
`include "laplacian_sharpen_stream_core_assert.svh"

module lss_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [lss_pkg::PIX_W-1:0] m_tdata,
    input logic                      m_tuser,
    input logic                      m_tlast
);
    import lss_pkg::*;

    logic [PIX_W+1:0] result_word;

    assign result_word = {m_tdata, m_tuser, m_tlast};

    // The end of a frame is always the end of a row.
    `LSS_ASSERT(a_frame_end_is_row_end, aclk, aresetn, m_tvalid && m_tlast |-> m_tuser)

    // Input is only held off while results are waiting in the queue.
    `LSS_ASSERT(a_stall_needs_backlog, aclk, aresetn, !s_tready |-> m_tvalid)

    // A result that is not taken stays as it is.
    `LSS_ASSERT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(result_word))

    // Once reset has been held, the queue is empty and the input is open.
    `LSS_ASSERT_RST(a_reset_empty, aclk, !aresetn ##1 !aresetn |=> !m_tvalid && s_tready)

endmodule

bind laplacian_sharpen_stream_core lss_checker u_lss_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the streaming 3x3 cross Laplacian sharpening core.
`timescale 1ns / 100ps

module testbench;
    import lss_pkg::*;

    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1780;

    localparam int STYLE_UNIFORM = 0;
    localparam int STYLE_SMOOTH  = 1;
    localparam int STYLE_CHECKER = 2;
    localparam int STYLE_EXTREME = 3;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    cfg_reg_t          cfg_addr  = REG_IMAGE_COLS;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    laplacian_sharpen_stream_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Predictor state, mirroring the core after reset.
    logic [COLS_W-1:0] width_reg  = COLS_RST;
    logic [ROW_W-1:0]  height_reg = ROWS_RST;
    logic [7:0]        upper_ln  [MAX_COLS];
    logic [7:0]        middle_ln [MAX_COLS];
    logic [7:0]        left_nb    = '0;
    logic [COLS_W-1:0] col_pos    = '0;
    logic [ROW_W-1:0]  row_pos    = '0;
    logic [COLS_W-1:0] drain_pos  = '0;

    res_t pending_pixels[$];
    int   errors   = 0;
    bit   no_idle  = 1'b0;

    function automatic logic [COLS_W-1:0] active_cols();
        if (width_reg == 0) return COLS_W'(1);
        if (width_reg > COLS_LIM) return COLS_LIM;
        return width_reg;
    endfunction

    function automatic logic [ROW_W-1:0] active_rows();
        return (height_reg == 0) ? ROW_W'(1) : height_reg;
    endfunction

    task automatic predict_sharpen(input req_t kind, input logic [7:0] pix);
        logic [COLS_W-1:0] cols;
        logic [ROW_W-1:0]  rows;
        logic [COLS_W-1:0] c;
        logic [7:0]        centre;
        int                val;
        res_t              res;
        cols = active_cols();
        rows = active_rows();
        if (kind == REQ_PIXEL) begin
            if (row_pos >= rows) return;
            c = (col_pos >= cols) ? cols - 1'b1 : col_pos;
            centre = middle_ln[c[COL_W-1:0]];
            if (row_pos >= 1) begin
                if (c == 0 || c == cols - 1'b1 || row_pos == 1 || row_pos == rows) begin
                    val = int'(centre);
                end else begin
                    val = 5 * int'(centre) - int'(upper_ln[c[COL_W-1:0]]) - int'(left_nb)
                          - int'(middle_ln[c[COL_W-1:0] + COL_W'(1)]) - int'(pix);
                    if (val > 255) val = 255;
                    else if (val < 0) val = 0;
                end
                res.pixel     = val[7:0];
                res.row_end   = (c == cols - 1'b1);
                res.frame_end = 1'b0;
                pending_pixels.push_back(res);
            end
            upper_ln[c[COL_W-1:0]]  = centre;
            middle_ln[c[COL_W-1:0]] = pix;
            left_nb      = centre;
            if (c == cols - 1'b1) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end else begin
                col_pos = c + 1'b1;
            end
        end else begin
            if (row_pos < rows) return;
            c = (drain_pos >= cols) ? cols - 1'b1 : drain_pos;
            res.pixel     = middle_ln[c[COL_W-1:0]];
            res.row_end   = (c == cols - 1'b1);
            res.frame_end = (c == cols - 1'b1);
            pending_pixels.push_back(res);
            if (c == cols - 1'b1) begin
                drain_pos = '0;
                col_pos   = '0;
                row_pos   = '0;
            end else begin
                drain_pos = c + 1'b1;
            end
        end
    endtask

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, leaving s_tvalid high for a following item.
    task automatic send_item(input req_t kind, input logic [7:0] pix);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sharpen(kind, pix);
        @(negedge aclk);
    endtask

    // Stops the input stream and waits until the core has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] cols_word,
                             input logic [CFG_W-1:0] rows_word);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IMAGE_COLS;
        cfg_wdata <= cols_word;
        @(posedge aclk);
        width_reg = cols_word[COLS_W-1:0];
        @(negedge aclk);
        cfg_addr  <= REG_IMAGE_ROWS;
        cfg_wdata <= rows_word;
        @(posedge aclk);
        height_reg = rows_word[ROW_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cfg_wdata <= CFG_W'($urandom_range(0, 4095));
    endtask

    // One whole frame in raster order followed by its drain ticks. With strays
    // set, ignored items are mixed in: early drain ticks and surplus pixels.
    task automatic run_frame(input int style, input bit strays);
        int cols;
        int rows;
        int base;
        int v;
        cols = active_cols();
        rows = active_rows();
        base = $urandom_range(0, 255);
        if (strays) send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                case (style)
                    STYLE_SMOOTH: begin
                        v = base + int'($urandom_range(0, 40)) - 20;
                        if (v < 0) v = 0;
                        else if (v > 255) v = 255;
                    end
                    STYLE_CHECKER: v = ((r + c) % 2 == 1) ? 255 : 0;
                    STYLE_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
                    default:       v = $urandom_range(0, 255);
                endcase
                if (strays && $urandom_range(0, 39) == 0)
                    send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
                send_item(REQ_PIXEL, v[7:0]);
            end
        end
        if (strays) begin
            repeat ($urandom_range(1, 2)) send_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
        end
        repeat (cols) send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_checkerboard_clamp();
        set_frame(4, 4);
        run_frame(STYLE_CHECKER, 1'b1);
    endtask

    task automatic test_single_row();
        set_frame(6, 1);
        run_frame(STYLE_UNIFORM, 1'b1);
    endtask

    task automatic test_single_column();
        set_frame(1, 5);
        run_frame(STYLE_UNIFORM, 1'b0);
        // A width of zero behaves as a single column.
        set_frame(0, 3);
        run_frame(STYLE_EXTREME, 1'b0);
    endtask

    task automatic test_size_extremes();
        // Bit 11 is not part of the width, so this frame is three pixels wide.
        set_frame(12'h803, 2);
        run_frame(STYLE_SMOOTH, 1'b0);
        set_frame(0, 0);
        run_frame(STYLE_UNIFORM, 1'b1);
        // Two columns make each new row read the entry written just before.
        set_frame(2, 3);
        run_frame(STYLE_EXTREME, 1'b1);
    endtask

    task automatic test_random_frames();
        int done;
        int cols;
        int rows;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            no_idle = (done > RANDOM_ITEMS * 17 / 20) || ($urandom_range(0, 4) == 0);
            if (done == 0 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 9))
                    7, 8:    cols = $urandom_range(13, 48);
                    9:       cols = $urandom_range(49, 200);
                    default: cols = $urandom_range(0, 12);
                endcase
                rows = $urandom_range(0, 10);
                set_frame({1'($urandom_range(0, 1)), 11'(cols)}, 12'(rows));
            end
            run_frame($urandom_range(STYLE_UNIFORM, STYLE_EXTREME),
                      $urandom_range(0, 2) == 0);
            done += int'(active_cols()) * (int'(active_rows()) + 1);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_checkerboard_clamp();
        test_single_row();
        test_single_column();
        test_size_extremes();
        test_random_frames();
        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver stalls come in short bursts.
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result: pixel %0d row_end %0b frame_end %0b",
                         $realtime, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata !== want.pixel || m_tuser !== want.row_end
                        || m_tlast !== want.frame_end) begin
                    $display("%0t: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             $realtime, want.pixel, want.row_end, want.frame_end,
                             m_tdata, m_tuser, m_tlast);
                    errors++;
                end
            end
        end
    end

    int stuck_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
